// ===== rtl/core/sia_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds the character codes, the power-of-ten table, the sequencer states and the
// control structs; no dependencies.
package sia_pkg;

  // Default width of the input value
  localparam int unsigned VALUE_BITS_DEF = 16;

  // ASCII codes that the converter emits
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_CR    = 7'h0D;

  // Largest digit value; a digit counter never passes it
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIV,
    ST_LF,
    ST_CR
  } sia_state_e;

  // Commands from the sequencer to the digit unit
  typedef struct packed {
    logic load;      // take a new magnitude, start at the top power
    logic step;      // subtract the current power, bump the digit
    logic next_pow;  // move down one power, clear the digit
  } sia_cmd_t;

  // Status from the digit unit back to the sequencer
  typedef struct packed {
    logic       ge;        // remainder still at or above the current power
    logic [3:0] digit;     // digit count gathered at the current power
    logic       last_pos;  // current power is ten to the zero
  } sia_stat_t;

  // Powers of ten that fit in 32 bits
  function automatic logic [31:0] pow10(input logic [3:0] idx);
    logic [31:0] p;
    unique case (idx)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd0;
    endcase
    return p;
  endfunction

  // Digit count of the largest magnitude, two to the (bits-1)
  function automatic int unsigned num_digits(input int unsigned bits);
    logic [63:0] limit;
    int unsigned n;
    limit = 64'd1 << (bits - 1);
    n = 1;
    for (int unsigned i = 1; i < 10; i++) begin
      if ({32'd0, pow10(4'(i))} <= limit) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII converter, top level.
// Sequencer and output register around sia_digit_unit; uses sia_pkg.
//
// Each accepted value gives one run of characters: '-' when negative, the decimal
// digits most significant first with no leading zeros (zero prints "0"), then line
// feed and carriage return, with last_o high on the carriage return. The most
// negative value prints in full. The block takes one value at a time and is busy
// until the carriage return has entered the output register. Digits come from one
// shared compare-and-subtract unit that takes off a power of ten per cycle, over five
// digit positions at 16 bits. The output register lets the next beat be loaded as the
// held one leaves.
module signed_int_to_decimal_ascii import sia_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [6:0]                   character_o,
  output logic                         last_o
);

  localparam int unsigned NumDigits = num_digits(VALUE_BITS);

  sia_state_e            state_q, state_d;
  sia_cmd_t              cmd;
  sia_stat_t             stat;
  logic [VALUE_BITS-1:0] mag_in;
  logic                  neg_q, neg_d;
  logic                  started_q, started_d;
  logic                  in_accept;
  logic                  can_load;
  logic                  show;
  logic                  emit;
  logic [6:0]            emit_char;
  logic                  emit_last;
  logic                  out_valid_q, out_valid_d;
  logic [6:0]            char_q, char_d;
  logic                  last_q, last_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign can_load   = !out_valid_q || out_ready_i;
  assign show       = (stat.digit != '0) || started_q || stat.last_pos;

  // Form the magnitude; the most negative value maps to its unsigned twin
  assign mag_in = value_i[VALUE_BITS-1] ? (~value_i + VALUE_BITS'(1)) : value_i;

  sia_digit_unit #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NumDigits)
  ) u_digit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .mag_i  (mag_in),
    .stat_o (stat)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = value_i[VALUE_BITS-1] ? ST_SIGN : ST_DIV;
        end
      end
      ST_SIGN: begin
        if (can_load) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!stat.ge && stat.last_pos && can_load) begin
          state_d = ST_LF;
        end
      end
      ST_LF: begin
        if (can_load) begin
          state_d = ST_CR;
        end
      end
      ST_CR: begin
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: unit commands and the beat to emit
  always_comb begin
    cmd       = '0;
    emit      = 1'b0;
    emit_char = CH_ZERO;
    emit_last = 1'b0;
    neg_d     = neg_q;
    started_d = started_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd.load  = 1'b1;
          neg_d     = value_i[VALUE_BITS-1];
          started_d = 1'b0;
        end
      end
      ST_SIGN: begin
        emit      = can_load;
        emit_char = CH_MINUS;
      end
      ST_DIV: begin
        if (stat.ge) begin
          cmd.step = 1'b1;
        end else if (!show) begin
          // drop a leading zero
          cmd.next_pow = 1'b1;
        end else if (can_load) begin
          emit         = 1'b1;
          emit_char    = CH_ZERO + {3'd0, stat.digit};
          started_d    = 1'b1;
          cmd.next_pow = !stat.last_pos;
        end
      end
      ST_LF: begin
        emit      = can_load;
        emit_char = CH_LF;
      end
      ST_CR: begin
        emit      = can_load;
        emit_char = CH_CR;
        emit_last = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Hold the output beat until taken; load a new one as the old leaves
  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      char_d      = emit_char;
      last_d      = emit_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // The block goes busy right after taking a value
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("ready after accepting a value");

  // A beat is never loaded over one that is still held
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> can_load)
    else $error("output beat overwritten");

  // The closing beat is always a carriage return
  a_last_is_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> character_o == CH_CR)
    else $error("last beat is not a carriage return");

  // A minus sign is only sent for a negative value
  a_sign_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SIGN |-> neg_q)
    else $error("sign state on a non-negative value");

endmodule

// ===== rtl/core/sia_digit_unit.sv =====
// Shared compare-and-subtract unit of the decimal converter.
// Holds the running remainder, the power index and the digit count; uses sia_pkg.
module sia_digit_unit import sia_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned NUM_DIGITS = num_digits(VALUE_BITS_DEF)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sia_cmd_t              cmd_i,
  input  logic [VALUE_BITS-1:0] mag_i,
  output sia_stat_t             stat_o
);

  localparam int unsigned IdxW   = $clog2(NUM_DIGITS);
  localparam logic [IdxW-1:0] TopIdx = IdxW'(NUM_DIGITS - 1);

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [3:0]            digit_q, digit_d;
  logic [VALUE_BITS-1:0] pow_cur;
  logic [31:0]           pow_full;
  logic                  ge;

  // Look up the current power; every used power fits in the value width
  assign pow_full = pow10(4'(idx_q));
  assign pow_cur  = pow_full[VALUE_BITS-1:0];
  assign ge       = (mag_q >= pow_cur);

  // Update remainder, power index and digit
  always_comb begin
    mag_d   = mag_q;
    idx_d   = idx_q;
    digit_d = digit_q;
    priority if (cmd_i.load) begin
      mag_d   = mag_i;
      idx_d   = TopIdx;
      digit_d = '0;
    end else if (cmd_i.step) begin
      mag_d   = mag_q - pow_cur;
      digit_d = digit_q + 4'd1;
    end else if (cmd_i.next_pow) begin
      idx_d   = idx_q - IdxW'(1);
      digit_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      digit_q <= '0;
    end else begin
      idx_q   <= idx_d;
      digit_q <= digit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  assign stat_o.ge       = ge;
  assign stat_o.digit    = digit_q;
  assign stat_o.last_pos = (idx_q == '0);

  // A step only happens while the remainder covers the power
  a_step_covered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && !cmd_i.load |-> ge)
    else $error("digit unit stepped below zero");

  // A digit never grows past nine
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q <= DIGIT_MAX)
    else $error("digit count out of range");

  // Moving down a power never happens from the lowest one
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.next_pow && !cmd_i.load |-> idx_q != '0)
    else $error("power index underflow");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for signed_int_to_decimal_ascii: directed and random values in,
// characters checked against a built-in decimal formatter. Depends on sia_pkg and the
// block itself.
module tb_top;
  import sia_pkg::*;

  localparam int unsigned VALUE_BITS = VALUE_BITS_DEF;
  localparam int RANDOM_VALUES = 460;
  localparam int DRAIN_CYCLES = 80;

  // One character of a text run
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  // Formats each accepted value and holds the characters still owed by the block
  class decimal_text_board;
    text_char_t pending_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // Queue the run of characters one value should produce
    function void note_value(input logic signed [VALUE_BITS-1:0] v);
      logic [VALUE_BITS:0] mag;
      logic [3:0]          digs[$];
      int unsigned         m;
      text_char_t          c;
      mag = v[VALUE_BITS-1] ? -{v[VALUE_BITS-1], v} : {1'b0, v};
      m = mag;
      // collect digits least significant first; zero still gives one digit
      do begin
        digs.push_front(4'(m % 10));
        m = m / 10;
      end while (m != 0);
      if (v[VALUE_BITS-1]) begin
        c.code = CH_MINUS;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      foreach (digs[i]) begin
        c.code = CH_ZERO + 7'(digs[i]);
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      c.code = CH_LF;
      c.last = 1'b0;
      pending_chars.push_back(c);
      c.code = CH_CR;
      c.last = 1'b1;
      pending_chars.push_back(c);
    endfunction

    // Compare one output beat with the oldest owed character
    function void check_char(input logic [6:0] code, input logic last);
      text_char_t exp_c;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, got %h last %b",
                 $time, code, last);
        errors++;
      end else begin
        exp_c = pending_chars.pop_front();
        if (code !== exp_c.code) begin
          $display("%0t: character mismatch: expected %h, got %h",
                   $time, exp_c.code, code);
          errors++;
        end
        if (last !== exp_c.last) begin
          $display("%0t: last mismatch: expected %b, got %b",
                   $time, exp_c.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] value_q = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [6:0]                   character;
  logic                         last;
  logic                         calm = 1'b0;

  decimal_text_board board = new();

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .value_i    (value_q),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .character_o(character),
    .last_o     (last)
  );

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Check every output beat, then pick the next ready
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid === 1'b1 && out_ready) begin
        board.check_char(character, last);
      end
      out_ready <= rst_ni && (calm || $urandom_range(99) >= 26);
    end
  end

  // Present one value and hold it until the beat is taken
  task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 26) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    value_q <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    board.note_value(v);
  endtask

  // Draw a random value, weighted toward each digit count and the range ends
  function automatic logic signed [VALUE_BITS-1:0] random_value();
    int unsigned mag;
    int unsigned top;
    logic signed [VALUE_BITS-1:0] v;
    case ($urandom_range(4))
      0: v = VALUE_BITS'($urandom);
      1: begin
        mag = $urandom_range(9);
        v = $urandom_range(1) ? -VALUE_BITS'(mag) : VALUE_BITS'(mag);
      end
      2: begin
        top = 10 ** $urandom_range(1, 4);
        mag = $urandom_range(top - 1, top / 10);
        v = $urandom_range(1) ? -VALUE_BITS'(mag) : VALUE_BITS'(mag);
      end
      3: begin
        mag = $urandom_range(15);
        v = $urandom_range(1) ? {1'b1, {(VALUE_BITS - 1){1'b0}}} + VALUE_BITS'(mag)
                              : {1'b0, {(VALUE_BITS - 1){1'b1}}} - VALUE_BITS'(mag);
      end
      default: begin
        mag = $urandom_range(32767, 10000);
        v = $urandom_range(1) ? -VALUE_BITS'(mag) : VALUE_BITS'(mag);
      end
    endcase
    return v;
  endfunction

  // Reset, stimulus and end of run
  initial begin
    int directed[] = '{0, 1, -1, 9, -9, 10, -10, 99, -100, 100, 999, -1000, 1000,
                       9999, -10000, 10000, 12345, -23456, 32767, -32768, -32767,
                       32766, 5, 0, -32768};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed values: zero, the range ends and every digit count
    foreach (directed[i]) begin
      send_value(VALUE_BITS'(directed[i]));
    end

    // Random values with a stretch of back-to-back traffic on both sides
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i == 180) calm <= 1'b1;
      if (i == 280) calm <= 1'b0;
      send_value(random_value());
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed character, then watch for stray beats
    while (board.pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
rtl/core/sia_pkg.sv
rtl/core/sia_digit_unit.sv
rtl/core/signed_int_to_decimal_ascii.sv
tb/tb_top.sv
